### src/rfc3339_to_epoch_ms_parser_macros.svh
// assertion helpers for the timestamp parser
`ifndef RFC3339_TO_EPOCH_MS_PARSER_MACROS_SVH
`define RFC3339_TO_EPOCH_MS_PARSER_MACROS_SVH
// implication checked every clock, muted in reset
`define R2E_ASSERT_IMP(lbl, a, c, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (a) |-> (c)) else $error(msg);
// implication checked on the following clock
`define R2E_ASSERT_NXT(lbl, a, c, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (a) |=> (c)) else $error(msg);
`endif

### src/r2e_pkg.sv
// ----------------------------------------------------------------------------
// r2e_pkg
// shared types and constants of the timestamp parser
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
package r2e_pkg;
  localparam int unsigned MsW = 49;

  typedef enum logic [5:0] {
    PH_FIELDS    = 6'b000001,
    PH_AFTER_SEC = 6'b000010,
    PH_DOT       = 6'b000100,
    PH_FRAC      = 6'b001000,
    PH_ZULU      = 6'b010000,
    PH_ZONE      = 6'b100000
  } phase_e;

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_C1   = 4'b0010,
    ST_C2   = 4'b0100,
    ST_C3   = 4'b1000
  } ctl_e;

  // controller to datapath
  typedef struct packed {
    logic take;   // beat accepted, consume a char
    logic fin;    // beat had last, latch done and valid state
    logic c1;
    logic c2;
    logic c3;     // final step, loads the output register
  } cmd_t;

  function automatic logic [4:0] month_len(input logic [3:0] m, input logic leap);
    logic [4:0] r;
    begin
      case (m)
        4'd2: r = leap ? 5'd29 : 5'd28;
        4'd4, 4'd6, 4'd9, 4'd11: r = 5'd30;
        default: r = 5'd31;
      endcase
      return r;
    end
  endfunction
endpackage

### src/r2e_ctrl.sv
// ----------------------------------------------------------------------------
// r2e_ctrl
// sequencer: accepts chars, runs the conversion steps, holds the result beat
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "rfc3339_to_epoch_ms_parser_macros.svh"
module r2e_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  input  logic          in_last_i,
  output logic          in_ready_o,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output r2e_pkg::cmd_t cmd_o
);
  import r2e_pkg::*;
  ctl_e st_q, st_d;
  logic ov_q, ov_d;

  assign in_ready_o  = (st_q == ST_IDLE);
  assign out_valid_o = ov_q;

  always_comb begin
    cmd_o      = '0;
    cmd_o.take = in_ready_o && in_valid_i;
    cmd_o.fin  = cmd_o.take && in_last_i;
    cmd_o.c1   = (st_q == ST_C1);
    cmd_o.c2   = (st_q == ST_C2);
    // last step waits until the output register is free or drains now
    cmd_o.c3   = (st_q == ST_C3) && (!ov_q || out_ready_i);
    ov_d       = ov_q;
    if (cmd_o.c3) ov_d = 1'b1;
    else if (out_ready_i) ov_d = 1'b0;
    st_d       = st_q;
    case (st_q)
      ST_IDLE: if (cmd_o.fin) st_d = ST_C1;
      ST_C1:   st_d = ST_C2;
      ST_C2:   st_d = ST_C3;
      ST_C3:   if (cmd_o.c3) st_d = ST_IDLE;
      default: st_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= ST_IDLE;
      ov_q <= 1'b0;
    end else begin
      st_q <= st_d;
      ov_q <= ov_d;
    end
  end

  `R2E_ASSERT_NXT(a_fin_seq, cmd_o.fin, st_q == ST_C1, "last beat did not start conversion")
  `R2E_ASSERT_IMP(a_no_take_busy, st_q != ST_IDLE, !cmd_o.take, "char taken while busy")
  `R2E_ASSERT_NXT(a_out_hold, out_valid_o && !out_ready_i, out_valid_o, "result dropped")
  `R2E_ASSERT_IMP(a_c3_slot, cmd_o.c3, !out_valid_o || out_ready_i, "waiting result overwritten")
endmodule

### src/r2e_dp.sv
// ----------------------------------------------------------------------------
// r2e_dp
// character parser state and days-from-civil conversion datapath
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module r2e_dp (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  r2e_pkg::cmd_t                  cmd_i,
  input  logic [7:0]                     char_i,
  output logic                           ok_o,
  output logic signed [r2e_pkg::MsW-1:0] ms_o
);
  import r2e_pkg::*;

  logic [4:0]  pos_q, pos_d;
  phase_e      ph_q, ph_d;
  logic [13:0] yr_q, yr_d;
  logic [6:0]  cen_q, cen_d, ylo_q, ylo_d;   // year split into century and low digits
  logic [6:0]  mo_q, mo_d, dy_q, dy_d, hr_q, hr_d, mi_q, mi_d, se_q, se_d;
  logic [9:0]  fr_q, fr_d;
  logic [2:0]  fd_q, fd_d;
  logic        zn_q, zn_d, bad_q, bad_d;
  logic [6:0]  zh_q, zh_d, zm_q, zm_d;

  logic       dig;
  logic [3:0] d;
  assign dig = (char_i >= 8'h30) && (char_i <= 8'h39);
  assign d   = dig ? 4'(char_i - 8'h30) : 4'd0;

  function automatic logic [6:0] p7(input logic [6:0] a, input logic [3:0] x);
    return 7'({a, 3'b0} + {a, 1'b0} + 7'(x));
  endfunction

  // days before the month in a year starting in march
  function automatic logic [8:0] month_base(input logic [3:0] m);
    logic [8:0] r;
    case (m)
      4'd1:    r = 9'd306;
      4'd2:    r = 9'd337;
      4'd4:    r = 9'd31;
      4'd5:    r = 9'd61;
      4'd6:    r = 9'd92;
      4'd7:    r = 9'd122;
      4'd8:    r = 9'd153;
      4'd9:    r = 9'd184;
      4'd10:   r = 9'd214;
      4'd11:   r = 9'd245;
      4'd12:   r = 9'd275;
      default: r = 9'd0;
    endcase
    return r;
  endfunction

  always_comb begin
    pos_d = pos_q; ph_d = ph_q; yr_d = yr_q; mo_d = mo_q; dy_d = dy_q;
    hr_d = hr_q; mi_d = mi_q; se_d = se_q; fr_d = fr_q; fd_d = fd_q;
    zn_d = zn_q; zh_d = zh_q; zm_d = zm_q; bad_d = bad_q;
    cen_d = cen_q; ylo_d = ylo_q;
    if (!bad_q) begin
      case (ph_q)
        PH_FIELDS: begin
          if (pos_q == 5'd4 || pos_q == 5'd7) begin
            if (char_i != "-") bad_d = 1'b1;
          end else if (pos_q == 5'd10) begin
            if (char_i != "T") bad_d = 1'b1;
          end else if (pos_q == 5'd13 || pos_q == 5'd16) begin
            if (char_i != ":") bad_d = 1'b1;
          end else if (!dig) begin
            bad_d = 1'b1;
          end else if (pos_q < 5'd4) begin
            yr_d = 14'({yr_q, 3'b0} + {yr_q, 1'b0} + 14'(d));
            if (pos_q < 5'd2) cen_d = p7(cen_q, d);
            else ylo_d = p7(ylo_q, d);
          end else if (pos_q < 5'd7) mo_d = p7(mo_q, d);
          else if (pos_q < 5'd10) dy_d = p7(dy_q, d);
          else if (pos_q < 5'd13) hr_d = p7(hr_q, d);
          else if (pos_q < 5'd16) mi_d = p7(mi_q, d);
          else se_d = p7(se_q, d);
          if (pos_q >= 5'd18) begin
            ph_d = PH_AFTER_SEC; pos_d = '0;
          end else pos_d = pos_q + 5'd1;
        end
        PH_AFTER_SEC, PH_DOT, PH_FRAC: begin
          if (ph_q == PH_AFTER_SEC && char_i == ".") ph_d = PH_DOT;
          else if (ph_q != PH_AFTER_SEC && dig) begin
            case (fd_q)
              3'd0: fr_d = 10'(fr_q + 10'(d) * 10'd100);
              3'd1: fr_d = 10'(fr_q + 10'(d) * 10'd10);
              3'd2: fr_d = 10'(fr_q + 10'(d));
              default: fr_d = fr_q;
            endcase
            if (fd_q < 3'd7) fd_d = fd_q + 3'd1;
            ph_d = PH_FRAC;
          end else if (ph_q == PH_DOT) bad_d = 1'b1;
          else if (char_i == "Z") ph_d = PH_ZULU;
          else if (char_i == "+" || char_i == "-") begin
            ph_d = PH_ZONE; zn_d = (char_i == "-"); pos_d = '0;
          end else bad_d = 1'b1;
        end
        PH_ZONE: begin
          if (pos_q >= 5'd5) bad_d = 1'b1;
          else if (pos_q == 5'd2) begin
            if (char_i != ":") bad_d = 1'b1;
          end else if (!dig) bad_d = 1'b1;
          else if (pos_q < 5'd2) zh_d = p7(zh_q, d);
          else zm_d = p7(zm_q, d);
          if (pos_q < 5'd31) pos_d = pos_q + 5'd1;
        end
        default: bad_d = 1'b1;
      endcase
    end
  end

  // conversion registers: inputs captured on the last beat, the rest on the steps
  logic        v_q, ok_q;
  logic signed [7:0] cc_q;      // century of the march-based year, -1 for year -1
  logic [6:0]  cl_q;            // low two digits of the march-based year
  logic [3:0]  cm_q;
  logic [4:0]  cd_q;
  logic [4:0]  ch_q;
  logic [5:0]  cmi_q, cs_q;
  logic [9:0]  cf_q;
  logic signed [12:0] off_q;    // zone offset in minutes
  logic [21:0] doe_q;
  logic signed [5:0] era_q;
  logic signed [31:0] days_q;
  logic signed [19:0] tod_q;    // seconds of day minus zone offset
  logic signed [MsW-1:0] ms_q;

  logic        leap, done, vnow;
  logic [6:0]  mo_v, dy_v;
  assign mo_v = mo_d;
  assign dy_v = dy_d;
  // year % 4 follows the low digits, a century year is leap when century % 4 is 0
  assign leap = (yr_d[1:0] == 2'b0) && ((ylo_d != 7'd0) || (cen_d[1:0] == 2'b0));
  assign done = (ph_d == PH_ZULU) || (ph_d == PH_ZONE && pos_d == 5'd5);
  assign vnow = !bad_d && done && mo_v >= 7'd1 && mo_v <= 7'd12 && hr_d <= 7'd23 &&
                mi_d <= 7'd59 && se_d <= 7'd59 && zh_d <= 7'd23 && zm_d <= 7'd59 &&
                dy_v >= 7'd1 && dy_v <= 7'(month_len(mo_v[3:0], leap));

  // january and february count to the previous year
  logic              yadj;
  logic signed [7:0] cc_v;
  logic [6:0]        cl_v;
  assign yadj = (mo_d <= 7'd2);
  always_comb begin
    cc_v = $signed({1'b0, cen_d});
    cl_v = ylo_d;
    if (yadj) begin
      if (ylo_d == 7'd0) begin
        cc_v = $signed({1'b0, cen_d}) - 8'sd1;
        cl_v = 7'd99;
      end else cl_v = ylo_d - 7'd1;
    end
  end

  // stage 1 values: year of era and day of year
  logic [8:0] yoe;
  logic [8:0] doy;
  assign yoe = 9'(9'(cc_q[1:0]) * 9'd100 + 9'(cl_q));
  assign doy = 9'(month_base(cm_q) + 9'(cd_q) - 9'd1);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q <= '0; ph_q <= PH_FIELDS; yr_q <= '0; mo_q <= '0; dy_q <= '0;
      hr_q <= '0; mi_q <= '0; se_q <= '0; fr_q <= '0; fd_q <= '0;
      zn_q <= 1'b0; zh_q <= '0; zm_q <= '0; bad_q <= 1'b0; v_q <= 1'b0;
      cen_q <= '0; ylo_q <= '0;
    end else if (cmd_i.fin) begin
      pos_q <= '0; ph_q <= PH_FIELDS; yr_q <= '0; mo_q <= '0; dy_q <= '0;
      hr_q <= '0; mi_q <= '0; se_q <= '0; fr_q <= '0; fd_q <= '0;
      zn_q <= 1'b0; zh_q <= '0; zm_q <= '0; bad_q <= 1'b0; v_q <= vnow;
      cen_q <= '0; ylo_q <= '0;
    end else if (cmd_i.take) begin
      pos_q <= pos_d; ph_q <= ph_d; yr_q <= yr_d; mo_q <= mo_d; dy_q <= dy_d;
      hr_q <= hr_d; mi_q <= mi_d; se_q <= se_d; fr_q <= fr_d; fd_q <= fd_d;
      zn_q <= zn_d; zh_q <= zh_d; zm_q <= zm_d; bad_q <= bad_d;
      cen_q <= cen_d; ylo_q <= ylo_d;
    end
  end

  // output register valid flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) ok_q <= 1'b0;
    else if (cmd_i.c3) ok_q <= v_q;
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.fin) begin
      cc_q <= cc_v; cl_q <= cl_v; cm_q <= mo_d[3:0]; cd_q <= dy_d[4:0]; ch_q <= hr_d[4:0];
      cmi_q <= mi_d[5:0]; cs_q <= se_d[5:0]; cf_q <= fr_d;
      off_q <= zn_d ? -13'(zh_d[4:0] * 11'd60 + 11'(zm_d[5:0]))
                    :  13'(zh_d[4:0] * 11'd60 + 11'(zm_d[5:0]));
    end
    if (cmd_i.c1) begin
      era_q <= 6'(cc_q >>> 2);
      doe_q <= 22'(22'(yoe) * 22'd365 + 22'(yoe[8:2]) - 22'(cc_q[1:0]) + 22'(doy));
    end
    if (cmd_i.c2) begin
      days_q <= 32'(32'(era_q) * 32'sd146097 + $signed({10'b0, doe_q}) - 32'sd719468);
      tod_q  <= 20'($signed({15'b0, ch_q}) * 20'sd3600 + $signed({14'b0, cmi_q}) * 20'sd60
                + $signed({14'b0, cs_q}) - 20'(off_q) * 20'sd60);
    end
    if (cmd_i.c3) begin
      ms_q <= MsW'(MsW'(days_q) * MsW'(86400000) + MsW'(tod_q) * MsW'(1000) + MsW'(cf_q));
    end
  end

  assign ok_o = ok_q;
  assign ms_o = ok_q ? ms_q : '0;
endmodule

### src/rfc3339_to_epoch_ms_parser.sv
// ----------------------------------------------------------------------------
// rfc3339_to_epoch_ms_parser
// streaming rfc 3339 timestamp to signed unix milliseconds
// ----------------------------------------------------------------------------
// result path: the last char beat starts steps C1, C2, C3; C3 loads the output register once free
// throughput: one char beat per cycle inside a string; after the last char the
//   three conversion steps hold input, longer only while an older result beat
//   still waits in the output register
// reset: asynchronous active low, parser returns to the start of a string
`timescale 1ns / 1ps
module rfc3339_to_epoch_ms_parser (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // char_code
  input  logic        s_axis_tlast,   // last_char
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [55:0] m_axis_tdata,   // epoch_ms[48:0], zero pad
  output logic        m_axis_tuser    // parse_ok
);
  import r2e_pkg::*;
  cmd_t cmd;
  logic ok;
  logic signed [MsW-1:0] ms;

  // sequencer
  r2e_ctrl u_ctrl (
    .clk_i, .rst_ni,
    .in_valid_i(s_axis_tvalid), .in_last_i(s_axis_tlast), .in_ready_o(s_axis_tready),
    .out_valid_o(m_axis_tvalid), .out_ready_i(m_axis_tready), .cmd_o(cmd)
  );

  // parser and conversion
  r2e_dp u_dp (
    .clk_i, .rst_ni, .cmd_i(cmd), .char_i(s_axis_tdata), .ok_o(ok), .ms_o(ms)
  );

  assign m_axis_tdata = {7'b0, ms};
  assign m_axis_tuser = ok;
endmodule
